// ===== hdl/assert_macros.svh =====
// assertion macros included by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition at one edge implies a consequence at the next
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/dawc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dawc_pkg
// Types, codes and helpers for the automaton word counter.
// ----------------------------------------------------------------------------
package dawc_pkg;

  localparam int NS = 256;
  localparam int SW = 8;
  localparam int CW = 9;
  localparam int VW = 30;
  localparam logic [VW-1:0] WORD_MOD = 30'd1000000007;

  localparam logic [1:0] OP_EDGE    = 2'd0;
  localparam logic [1:0] OP_ACCEPT  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [4:0] CMD_NONE        = 5'd0;
  localparam logic [4:0] CMD_LOAD        = 5'd1;
  localparam logic [4:0] CMD_M_INIT      = 5'd2;
  localparam logic [4:0] CMD_EDGE_RD_EI  = 5'd3;
  localparam logic [4:0] CMD_M_CHECK     = 5'd4;
  localparam logic [4:0] CMD_M_RESTART   = 5'd5;
  localparam logic [4:0] CMD_D_INIT      = 5'd6;
  localparam logic [4:0] CMD_EDGE_RD_TOP = 5'd7;
  localparam logic [4:0] CMD_D_CHECK     = 5'd8;
  localparam logic [4:0] CMD_D_POP       = 5'd9;
  localparam logic [4:0] CMD_D_RESTORE   = 5'd10;
  localparam logic [4:0] CMD_C_INIT      = 5'd11;
  localparam logic [4:0] CMD_C_LOADV     = 5'd12;
  localparam logic [4:0] CMD_C_READV     = 5'd13;
  localparam logic [4:0] CMD_C_ACC0      = 5'd14;
  localparam logic [4:0] CMD_C_CHECKE    = 5'd15;
  localparam logic [4:0] CMD_C_ADD       = 5'd16;
  localparam logic [4:0] CMD_C_STORE     = 5'd17;
  localparam logic [4:0] CMD_S_INIT      = 5'd18;
  localparam logic [4:0] CMD_S_READ      = 5'd19;
  localparam logic [4:0] CMD_S_ADD       = 5'd20;
  localparam logic [4:0] CMD_FINISH      = 5'd21;

  typedef struct packed {
    logic [4:0] code;
  } dawc_cmd_t;

  typedef struct packed {
    logic ei_left;
    logic ti_left;
    logic changed;
    logic cycle;
    logic last_frame;
    logic k_zero;
    logic c_match;
    logic s_left;
  } dawc_status_t;

  function automatic logic [VW-1:0] mod_add(input logic [VW-1:0] x, input logic [VW-1:0] y);
    logic [VW:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, WORD_MOD}) begin
      sum = sum - {1'b0, WORD_MOD};
    end
    return sum[VW-1:0];
  endfunction

endpackage

// ===== hdl/dfa_accepted_word_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_accepted_word_counter_core
// Counts words accepted by a loaded automaton, modulo 1000000007.
// ----------------------------------------------------------------------------
// Transition and accept items are taken one per cycle and produce no result.
// A compute item runs a job through one edge memory port in phases: marking
// passes over the E stored edges (at most the longest backward chain + 1
// passes), a depth-first walk, path counting over the V states in use and a
// final sum. In that time no item is taken.
// The result stays on out_* until taken; edges, marks and flags clear at its issue.
module dfa_accepted_word_counter_core import dawc_pkg::*; #(
  parameter int MAX_EDGES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [CW-1:0] cfg_state_count,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [SW-1:0] in_from_state,
  input  logic [SW-1:0] in_to_state,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_word_count,
  output logic          out_is_infinite,
  output logic          out_edges_dropped
);

  `include "assert_macros.svh"

  dawc_cmd_t    cmd;
  dawc_status_t st;

  assign cfg_ready = 1'b1;

  dawc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  dawc_dpath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_state_count),
    .in_op        (in_op),
    .in_from      (in_from_state),
    .in_to        (in_to_state),
    .res_count    (out_word_count),
    .res_infinite (out_is_infinite),
    .res_dropped  (out_edges_dropped)
  );

  `ASSERT_ALWAYS(a_inf_zero, !(out_valid && out_is_infinite && out_word_count != '0), "infinite with nonzero count")
  `ASSERT_ALWAYS(a_count_range, !out_valid || out_word_count < WORD_MOD, "count not reduced")
  `ASSERT_NEXT(a_compute_busy, in_valid && in_ready && in_op == OP_COMPUTE, !in_ready, "item taken during compute")

endmodule

// ===== hdl/dawc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dawc_ctrl
// Sequencer: load handshake, marking, walk; counting and summing if no loop found.
// ----------------------------------------------------------------------------
module dawc_ctrl import dawc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_op,
  output logic         out_valid,
  input  logic         out_ready,
  input  dawc_status_t st,
  output dawc_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MINIT  = 5'd1;
  localparam logic [4:0] S_MSCAN  = 5'd2;
  localparam logic [4:0] S_MCHK   = 5'd3;
  localparam logic [4:0] S_DINIT  = 5'd4;
  localparam logic [4:0] S_DSCAN  = 5'd5;
  localparam logic [4:0] S_DCHK   = 5'd6;
  localparam logic [4:0] S_DPOP   = 5'd7;
  localparam logic [4:0] S_DREST  = 5'd8;
  localparam logic [4:0] S_CINIT  = 5'd9;
  localparam logic [4:0] S_CTEST  = 5'd10;
  localparam logic [4:0] S_CRDV   = 5'd11;
  localparam logic [4:0] S_CACC   = 5'd12;
  localparam logic [4:0] S_CSCAN  = 5'd13;
  localparam logic [4:0] S_CCHK   = 5'd14;
  localparam logic [4:0] S_CADD   = 5'd15;
  localparam logic [4:0] S_CSTORE = 5'd16;
  localparam logic [4:0] S_SINIT  = 5'd17;
  localparam logic [4:0] S_SSCAN  = 5'd18;
  localparam logic [4:0] S_SADD   = 5'd19;
  localparam logic [4:0] S_FIN    = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.code      = CMD_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_COMPUTE) begin
            state_nxt = S_MINIT;
          end else begin
            cmd.code = CMD_LOAD;
          end
        end
      end
      S_MINIT: begin
        cmd.code  = CMD_M_INIT;
        state_nxt = S_MSCAN;
      end
      S_MSCAN: begin
        if (st.ei_left) begin
          cmd.code  = CMD_EDGE_RD_EI;
          state_nxt = S_MCHK;
        end else if (st.changed) begin
          cmd.code = CMD_M_RESTART;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_MCHK: begin
        cmd.code  = CMD_M_CHECK;
        state_nxt = S_MSCAN;
      end
      S_DINIT: begin
        cmd.code  = CMD_D_INIT;
        state_nxt = S_DSCAN;
      end
      S_DSCAN: begin
        if (st.ti_left) begin
          cmd.code  = CMD_EDGE_RD_TOP;
          state_nxt = S_DCHK;
        end else begin
          state_nxt = S_DPOP;
        end
      end
      S_DCHK: begin
        cmd.code  = CMD_D_CHECK;
        state_nxt = st.cycle ? S_FIN : S_DSCAN;
      end
      S_DPOP: begin
        cmd.code  = CMD_D_POP;
        state_nxt = st.last_frame ? S_CINIT : S_DREST;
      end
      S_DREST: begin
        cmd.code  = CMD_D_RESTORE;
        state_nxt = S_DSCAN;
      end
      S_CINIT: begin
        cmd.code  = CMD_C_INIT;
        state_nxt = S_CTEST;
      end
      S_CTEST: begin
        if (st.k_zero) begin
          state_nxt = S_SINIT;
        end else begin
          cmd.code  = CMD_C_LOADV;
          state_nxt = S_CRDV;
        end
      end
      S_CRDV: begin
        cmd.code  = CMD_C_READV;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.code  = CMD_C_ACC0;
        state_nxt = S_CSCAN;
      end
      S_CSCAN: begin
        if (st.ei_left) begin
          cmd.code  = CMD_EDGE_RD_EI;
          state_nxt = S_CCHK;
        end else begin
          state_nxt = S_CSTORE;
        end
      end
      S_CCHK: begin
        cmd.code  = CMD_C_CHECKE;
        state_nxt = st.c_match ? S_CADD : S_CSCAN;
      end
      S_CADD: begin
        cmd.code  = CMD_C_ADD;
        state_nxt = S_CSCAN;
      end
      S_CSTORE: begin
        cmd.code  = CMD_C_STORE;
        state_nxt = S_CTEST;
      end
      S_SINIT: begin
        cmd.code  = CMD_S_INIT;
        state_nxt = S_SSCAN;
      end
      S_SSCAN: begin
        if (st.s_left) begin
          cmd.code  = CMD_S_READ;
          state_nxt = S_SADD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SADD: begin
        cmd.code  = CMD_S_ADD;
        state_nxt = S_SSCAN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.code      = CMD_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/dawc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dawc_dpath
// Edge, stack, finish and path count memories, flags and arithmetic.
// ----------------------------------------------------------------------------
module dawc_dpath import dawc_pkg::*; #(
  parameter int MAX_EDGES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dawc_cmd_t       cmd,
  output dawc_status_t    st,
  input  logic            cfg_we,
  input  logic [CW-1:0]   cfg_data,
  input  logic [1:0]      in_op,
  input  logic [SW-1:0]   in_from,
  input  logic [SW-1:0]   in_to,
  output logic [VW-1:0]   res_count,
  output logic            res_infinite,
  output logic            res_dropped
);

  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EA = $clog2(MAX_EDGES);
  localparam int FW = EW + SW;

  logic [2*SW-1:0] edge_mem [MAX_EDGES];
  logic [FW-1:0]   stack_mem [NS];
  logic [SW-1:0]   fin_mem [NS];
  logic [VW-1:0]   pc_mem [NS];

  logic [2*SW-1:0] edge_q_r;
  logic [FW-1:0]   stack_q_r;
  logic [SW-1:0]   fin_q_r;
  logic [VW-1:0]   pc_q_r;
  logic [SW-1:0]   pc_a_r;

  logic [CW-1:0]   n_r;
  logic [EW-1:0]   edge_total_r, ei_r, top_i_r;
  logic            overflow_r, changed_r, infinite_r;
  logic [NS-1:0]   accept_r, co_r, gray_r, black_r, pcv_r;
  logic [SW-1:0]   top_v_r, v_r;
  logic [CW-1:0]   sp_r, fin_r, k_r, s_r;
  logic [VW-1:0]   acc_r, total_r;
  logic [VW-1:0]   cnt_r;
  logic            inf_out_r, drop_out_r;

  logic [SW-1:0]   ea, eb;
  logic            a_in, b_in, hit, white_b;
  logic [NS-1:0]   nmask;
  logic [VW-1:0]   pcval;
  logic [EA-1:0]   edge_addr;
  logic [SW-1:0]   pc_addr;
  logic [CW-1:0]   sp_m2, k_m1, sp_m1;
  logic            edge_we;

  assign ea      = edge_q_r[2*SW-1:SW];
  assign eb      = edge_q_r[SW-1:0];
  assign a_in    = ({1'b0, ea} < n_r);
  assign b_in    = ({1'b0, eb} < n_r);
  assign hit     = (ea == top_v_r) && b_in;
  assign white_b = !gray_r[eb] && !black_r[eb];
  assign pcval   = pcv_r[pc_a_r] ? pc_q_r : ((pc_a_r == '0) ? VW'(1) : '0);
  assign sp_m1   = sp_r - CW'(1);
  assign sp_m2   = sp_r - CW'(2);
  assign k_m1    = k_r - CW'(1);
  assign edge_we = (cmd.code == CMD_LOAD) && (in_op == OP_EDGE) &&
                   (edge_total_r < EW'(MAX_EDGES));

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      nmask[s] = (CW'(s) < n_r);
    end
  end

  assign st.ei_left    = (ei_r < edge_total_r);
  assign st.ti_left    = (top_i_r < edge_total_r);
  assign st.changed    = changed_r;
  assign st.cycle      = hit && gray_r[eb] && co_r[eb];
  assign st.last_frame = (sp_r == CW'(1));
  assign st.k_zero     = (k_r == '0);
  assign st.c_match    = (eb == v_r) && a_in;
  assign st.s_left     = (s_r < n_r);

  assign edge_addr = (cmd.code == CMD_EDGE_RD_TOP) ? top_i_r[EA-1:0] : ei_r[EA-1:0];

  always_comb begin
    case (cmd.code)
      CMD_C_READV:  pc_addr = fin_q_r;
      CMD_C_CHECKE: pc_addr = ea;
      default:      pc_addr = s_r[SW-1:0];
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total_r[EA-1:0]] <= {in_from, in_to};
    end
    edge_q_r <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_D_CHECK && hit && white_b && sp_r < CW'(NS)) begin
      stack_mem[sp_m1[SW-1:0]] <= {top_v_r, top_i_r + EW'(1)};
    end
    stack_q_r <= stack_mem[sp_m2[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_D_POP && fin_r < CW'(NS)) begin
      fin_mem[fin_r[SW-1:0]] <= top_v_r;
    end
    fin_q_r <= fin_mem[k_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_C_STORE) begin
      pc_mem[v_r] <= acc_r;
    end
    pc_q_r <= pc_mem[pc_addr];
    pc_a_r <= pc_addr;
  end

  // scratch registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_M_INIT, CMD_M_RESTART: begin
        ei_r <= '0;
      end
      CMD_M_CHECK, CMD_C_CHECKE: begin
        ei_r <= ei_r + EW'(1);
      end
      CMD_D_INIT: begin
        top_v_r <= '0;
        top_i_r <= '0;
        sp_r    <= CW'(1);
        fin_r   <= '0;
      end
      CMD_D_CHECK: begin
        if (hit && white_b && sp_r < CW'(NS)) begin
          top_v_r <= eb;
          top_i_r <= '0;
          sp_r    <= sp_r + CW'(1);
        end else begin
          top_i_r <= top_i_r + EW'(1);
        end
      end
      CMD_D_POP: begin
        sp_r <= sp_m1;
        if (fin_r < CW'(NS)) begin
          fin_r <= fin_r + CW'(1);
        end
      end
      CMD_D_RESTORE: begin
        top_v_r <= stack_q_r[FW-1:EW];
        top_i_r <= stack_q_r[EW-1:0];
      end
      CMD_C_INIT: begin
        k_r <= fin_r;
      end
      CMD_C_READV: begin
        v_r <= fin_q_r;
      end
      CMD_C_ACC0: begin
        acc_r <= pcval;
        ei_r  <= '0;
      end
      CMD_C_ADD: begin
        acc_r <= mod_add(acc_r, pcval);
      end
      CMD_C_STORE: begin
        k_r <= k_m1;
      end
      CMD_S_INIT: begin
        s_r     <= '0;
        total_r <= '0;
      end
      CMD_S_ADD: begin
        if (accept_r[pc_a_r]) begin
          total_r <= mod_add(total_r, pcval);
        end
        s_r <= s_r + CW'(1);
      end
      CMD_FINISH: begin
        cnt_r      <= infinite_r ? '0 : total_r;
        inf_out_r  <= infinite_r;
        drop_out_r <= overflow_r;
      end
      default: begin
      end
    endcase
  end

  // control state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= CW'(1);
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      accept_r     <= '0;
      co_r         <= '0;
      gray_r       <= '0;
      black_r      <= '0;
      pcv_r        <= '0;
      changed_r    <= 1'b0;
      infinite_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_data == '0) begin
          n_r <= CW'(1);
        end else if (cfg_data > CW'(NS)) begin
          n_r <= CW'(NS);
        end else begin
          n_r <= cfg_data;
        end
      end
      case (cmd.code)
        CMD_LOAD: begin
          if (in_op == OP_EDGE) begin
            if (edge_total_r < EW'(MAX_EDGES)) begin
              edge_total_r <= edge_total_r + EW'(1);
            end else begin
              overflow_r <= 1'b1;
            end
          end else if (in_op == OP_ACCEPT) begin
            accept_r[in_from] <= 1'b1;
          end
        end
        CMD_M_INIT: begin
          co_r       <= accept_r & nmask;
          changed_r  <= 1'b0;
          infinite_r <= 1'b0;
        end
        CMD_M_RESTART: begin
          changed_r <= 1'b0;
        end
        CMD_M_CHECK: begin
          if (a_in && b_in && co_r[eb] && !co_r[ea]) begin
            co_r[ea]  <= 1'b1;
            changed_r <= 1'b1;
          end
        end
        CMD_D_INIT: begin
          gray_r[0] <= 1'b1;
        end
        CMD_D_CHECK: begin
          if (hit && white_b && sp_r < CW'(NS)) begin
            gray_r[eb] <= 1'b1;
          end
          if (st.cycle) begin
            infinite_r <= 1'b1;
          end
        end
        CMD_D_POP: begin
          gray_r[top_v_r]  <= 1'b0;
          black_r[top_v_r] <= 1'b1;
        end
        CMD_C_STORE: begin
          pcv_r[v_r] <= 1'b1;
        end
        CMD_FINISH: begin
          edge_total_r <= '0;
          overflow_r   <= 1'b0;
          accept_r     <= '0;
          co_r         <= '0;
          gray_r       <= '0;
          black_r      <= '0;
          pcv_r        <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_count    = cnt_r;
  assign res_infinite = inf_out_r;
  assign res_dropped  = drop_out_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the automaton word counter core.
// ----------------------------------------------------------------------------
// A directed table (empty automaton, self loops, ignored opcodes, clamped
// state counts, repeated marks) is followed by random graphs: well-formed
// acyclic graphs, cyclic ones and noise edges. Every result is compared
// field by field with a value from the table or a software model of the counter.
// Both sides idle at random. One phase holds off the receiver for a long
// stretch; in the last phase the sender waits for all counts before each graph.
// ----------------------------------------------------------------------------
module tb;
  import dawc_pkg::*;

  localparam int EDGE_CAP    = 1024;
  localparam int IDLE_LIMIT  = 3000000;
  localparam longint MODULUS = 64'd1000000007;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GRAY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  typedef struct packed {
    logic [VW-1:0] words;
    logic          infinite;
    logic          dropped;
  } count_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] op;
    logic [7:0] src;
    logic [7:0] dst;
    logic [8:0] cfg_value;
    bit         typed;
    count_t     want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_state_count = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    in_op = OP_EDGE;
  logic [SW-1:0] in_from_state = '0;
  logic [SW-1:0] in_to_state = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VW-1:0] out_word_count;
  logic          out_is_infinite;
  logic          out_edges_dropped;

  dfa_accepted_word_counter_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_state_count   (cfg_state_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_from_state     (in_from_state),
    .in_to_state       (in_to_state),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_count    (out_word_count),
    .out_is_infinite   (out_is_infinite),
    .out_edges_dropped (out_edges_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [15:0] m_edges [EDGE_CAP];
  int          m_edge_cnt;
  bit          m_accept [NS];
  bit          m_coreach [NS];
  logic [1:0]  m_color [NS];
  longint      m_paths [NS];
  int          m_finish [NS];
  int          m_stk_v [NS];
  int          m_stk_next [NS];
  bit          m_overflow;
  int          m_state_reg;

  count_t counts_due[$];
  int     errors;
  int     items_sent;
  int     computes_done;
  int     infinite_seen;
  int     drops_seen;
  bit     idle_en = 1'b1;
  bit     hold_req = 1'b0;
  int     hold_left;
  int     quiet_cycles;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic void clear_model();
    m_edge_cnt = 0;
    m_overflow = 0;
    for (int s = 0; s < NS; s++) begin
      m_accept[s]  = 0;
      m_coreach[s] = 0;
      m_color[s]   = COLOR_WHITE;
      m_paths[s]   = 0;
    end
    m_paths[0] = 1;
  endfunction

  function automatic count_t count_words();
    count_t r;
    int     n;
    bit     grew;
    bit     loop_found;
    int     sp;
    int     fin;
    int     v;
    int     a;
    int     b;
    bit     moved;
    longint acc;
    longint total;
    n = m_state_reg < 1 ? 1 : (m_state_reg > NS ? NS : m_state_reg);
    for (int s = 0; s < n; s++) m_coreach[s] = m_accept[s];
    grew = 1;
    while (grew) begin
      grew = 0;
      for (int i = 0; i < m_edge_cnt; i++) begin
        a = m_edges[i][15:8];
        b = m_edges[i][7:0];
        if (a < n && b < n && m_coreach[b] && !m_coreach[a]) begin
          m_coreach[a] = 1;
          grew = 1;
        end
      end
    end
    // iterative depth-first walk from the start state
    loop_found = 0;
    fin = 0;
    m_color[0] = COLOR_GRAY;
    m_stk_v[0] = 0;
    m_stk_next[0] = 0;
    sp = 1;
    while (sp > 0 && !loop_found) begin
      v = m_stk_v[sp-1];
      moved = 0;
      for (int i = m_stk_next[sp-1]; i < m_edge_cnt && !moved; i++) begin
        a = m_edges[i][15:8];
        b = m_edges[i][7:0];
        if (a == v && b < n) begin
          m_stk_next[sp-1] = i + 1;
          moved = 1;
          if (m_color[b] == COLOR_WHITE) begin
            if (sp < NS) begin
              m_color[b] = COLOR_GRAY;
              m_stk_v[sp] = b;
              m_stk_next[sp] = 0;
              sp++;
            end
          end else if (m_color[b] == COLOR_GRAY && m_coreach[b]) begin
            loop_found = 1;
          end
        end
      end
      if (!moved && !loop_found) begin
        m_color[v] = COLOR_BLACK;
        if (fin < NS) begin
          m_finish[fin] = v;
          fin++;
        end
        sp--;
      end
    end
    total = 0;
    if (!loop_found) begin
      for (int k = fin; k > 0; k--) begin
        v = m_finish[k-1];
        acc = m_paths[v];
        for (int i = 0; i < m_edge_cnt; i++) begin
          a = m_edges[i][15:8];
          b = m_edges[i][7:0];
          if (b == v && a < n) acc = (acc + m_paths[a]) % MODULUS;
        end
        m_paths[v] = acc;
      end
      for (int s = 0; s < n; s++)
        if (m_accept[s]) total = (total + m_paths[s]) % MODULUS;
    end
    r.words    = VW'(total);
    r.infinite = loop_found;
    r.dropped  = m_overflow;
    clear_model();
    return r;
  endfunction

  task automatic wait_drained();
    while (counts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_state_count(input logic [8:0] value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_state_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_state_reg = value;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] src, input logic [7:0] dst,
                           input bit typed, input count_t want);
    count_t predicted;
    if (idle_en && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_from_state <= src;
    in_to_state   <= dst;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    case (op)
      OP_EDGE: begin
        if (m_edge_cnt < EDGE_CAP) begin
          m_edges[m_edge_cnt] = {src, dst};
          m_edge_cnt++;
        end else begin
          m_overflow = 1;
        end
      end
      OP_ACCEPT: m_accept[src] = 1;
      OP_COMPUTE: begin
        predicted = count_words();
        counts_due.insert(counts_due.size(), typed ? want : predicted);
      end
      default: ;
    endcase
  endtask

  task automatic finish_items();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random graph over n states plus noise items, then a compute
  task automatic random_graph(input int n, input int edges, input bit acyclic);
    int     a;
    int     b;
    count_t none;
    none = '0;
    for (int e = 0; e < edges; e++) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      if (acyclic && a >= b) begin
        if (a == b) b = (a + 1 < n) ? a + 1 : a;
        else begin
          a = a ^ b; b = a ^ b; a = a ^ b;
        end
        if (a == b) continue;
      end
      send_item(OP_EDGE, 8'(a), 8'(b), 0, none);
      if ($urandom_range(99) < 20)
        send_item(OP_ACCEPT, 8'($urandom_range(n - 1)), 8'($urandom), 0, none);
      if ($urandom_range(99) < 4)
        send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 0, none);
      if ($urandom_range(99) < 5)
        send_item(OP_EDGE, 8'($urandom), 8'($urandom), 0, none);
    end
    send_item(OP_ACCEPT, 8'($urandom_range(n - 1)), 8'($urandom), 0, none);
    send_item(OP_COMPUTE, 8'($urandom), 8'($urandom), 0, none);
  endtask

  function automatic row_t mk(input row_kind_e kind, input logic [1:0] op, input int src,
                              input int dst, input int cfg_value, input bit typed,
                              input int words, input bit infinite);
    row_t r;
    r.kind      = kind;
    r.op        = op;
    r.src       = 8'(src);
    r.dst       = 8'(dst);
    r.cfg_value = 9'(cfg_value);
    r.typed     = typed;
    r.want      = '{VW'(words), infinite, 1'b0};
    return r;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 23);
    end
  end

  // result checker
  always @(posedge clk) begin
    count_t want;
    if (rst_n && out_valid && out_ready) begin
      if (counts_due.size() == 0) begin
        report("unexpected item", 32'(out_word_count), 32'd0);
      end else begin
        want = counts_due.pop_front();
        computes_done++;
        if (out_is_infinite) infinite_seen++;
        if (out_edges_dropped) drops_seen++;
        if (out_word_count !== want.words)
          report("word_count", 32'(out_word_count), 32'(want.words));
        if (out_is_infinite !== want.infinite)
          report("is_infinite", 32'(out_is_infinite), 32'(want.infinite));
        if (out_edges_dropped !== want.dropped)
          report("edges_dropped", 32'(out_edges_dropped), 32'(want.dropped));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("watchdog expired with %0d counts outstanding", counts_due.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    row_t   plan[$];
    count_t none;
    int     sizes[6];
    int     n;
    none = '0;
    errors = 0;
    items_sent = 0;
    computes_done = 0;
    infinite_seen = 0;
    drops_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    m_state_reg = 1;
    clear_model();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty automaton, single accepting start, self loop, ignored opcode
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 1, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 1, 1, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 1, 0, 1));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_UNUSED, 255, 255, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 255, 255, 0, 1, 0, 0));
    // full range, parallel edges, repeated mark
    plan.insert(plan.size(), mk(ROW_CFG, OP_EDGE, 0, 0, 256, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 255, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 255, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 255, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 255, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 1, 2, 0));
    // zero count acts as one: edge and mark past the count are skipped
    plan.insert(plan.size(), mk(ROW_CFG, OP_EDGE, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 1, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 1, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 1, 1, 0));
    // oversize count clamps
    plan.insert(plan.size(), mk(ROW_CFG, OP_EDGE, 0, 0, 511, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 128, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 128, 255, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 255, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 255, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 0, 0, 0));
    // cycle that cannot reach an accepting state
    plan.insert(plan.size(), mk(ROW_CFG, OP_EDGE, 0, 0, 3, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 0, 1, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 1, 2, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_EDGE, 2, 1, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_ACCEPT, 0, 0, 0, 0, 0, 0));
    plan.insert(plan.size(), mk(ROW_ITEM, OP_COMPUTE, 0, 0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        finish_items();
        write_state_count(plan[i].cfg_value);
      end else begin
        send_item(plan[i].op, plan[i].src, plan[i].dst, plan[i].typed, plan[i].want);
      end
    end
    finish_items();

    // receiver holds off while computes queue up behind it
    write_state_count(9'd6);
    hold_req = 1;
    for (int g = 0; g < 3; g++) random_graph(6, 6, 1);
    finish_items();

    // random graphs, sender waits for every count before each new setting
    sizes = '{2, 5, 9, 16, 256, 1};
    for (int g = 0; g < 45; g++) begin
      idle_en = !(g >= 10 && g < 16);
      n = sizes[$urandom_range(5)];
      finish_items();
      write_state_count(g % 9 == 8 ? 9'($urandom) : 9'(n));
      random_graph(n, $urandom_range(22, 4), $urandom_range(99) < 65);
    end
    finish_items();

    wait_drained();
    repeat (50) @(posedge clk);
    $display("tb: %0d items sent, %0d counts checked, %0d infinite, %0d with dropped edges",
             items_sent, computes_done, infinite_seen, drops_seen);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dawc_pkg.sv
hdl/dawc_ctrl.sv
hdl/dawc_dpath.sv
hdl/dfa_accepted_word_counter_core.sv
test/tb.sv
